/* rtl/mobius_linear_sieve_core_assert.svh */
// assertion macros shared by the sieve rtl
`ifndef MOBIUS_LINEAR_SIEVE_CORE_ASSERT_SVH
`define MOBIUS_LINEAR_SIEVE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MLS_CHK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define MLS_CHK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mls_pkg.sv */
// shared types and constants for the mobius linear sieve
`timescale 1ns / 1ps
package mls_pkg;

  // fixed field widths
  localparam int NUM_W   = 17;
  localparam int MU_W    = 2;

  // parameter defaults
  localparam int DEF_MAX_N       = 65536;
  localparam int DEF_PRIME_SLOTS = 8192;

  // limit register reset value
  localparam logic [NUM_W-1:0] LIMIT_RESET = 17'd65536;

  typedef logic signed [MU_W-1:0] mu_t;

  localparam mu_t MU_ZERO = 2'sb00;
  localparam mu_t MU_ONE  = 2'sb01;
  localparam mu_t MU_NEG  = 2'sb11;

endpackage

/* rtl/mobius_linear_sieve_core.sv */
// top level of the mobius linear sieve: control sequencer and state memories
//
//   channel | direction | signals
//   in      | input     | in_valid, in_ready, in_restart
//   out     | output    | out_valid, out_ready, out_number/mobius/is_prime/last/finished
//   cfg     | input     | cfg_we, cfg_wdata (limit)
//
// one item at a time: a number is read from the entry memory (EVAL, NRD), then walks the
// prime list in a read / multiply / check loop (WRD, WMUL, WCHK) until the product passes
// the limit, the prime reaches its smallest factor or the stored primes run out, then OUT.
// a finished tick goes from EVAL straight to OUT.
// after reset a clearing pass over entries 0 .. MAX_N runs before the first item is taken.
// a restart item first clears entries 0 .. highest written address (one per cycle).
// a result waiting in the output register holds the sequencer in its last state.
`timescale 1ns / 1ps
`include "mobius_linear_sieve_core_assert.svh"
module mobius_linear_sieve_core #(
  parameter int MAX_N       = mls_pkg::DEF_MAX_N,
  parameter int PRIME_SLOTS = mls_pkg::DEF_PRIME_SLOTS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [mls_pkg::NUM_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_restart,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mls_pkg::NUM_W-1:0] out_number,
  output mls_pkg::mu_t              out_mobius,
  output logic                      out_is_prime,
  output logic                      out_last,
  output logic                      out_finished
);

  // derived widths
  localparam int NW   = $clog2(MAX_N + 1);
  localparam int LW   = (NW > mls_pkg::NUM_W) ? NW : mls_pkg::NUM_W;
  localparam int MW   = 2 * NW;
  localparam int PW   = $clog2(PRIME_SLOTS + 1);
  localparam int PIW  = (PRIME_SLOTS > 1) ? $clog2(PRIME_SLOTS) : 1;
  localparam int EDW  = NW + mls_pkg::MU_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR  = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_NRD  = 3'd3;
  localparam logic [2:0] ST_WRD  = 3'd4;
  localparam logic [2:0] ST_WMUL = 3'd5;
  localparam logic [2:0] ST_WCHK = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]                state_r, state_nxt;
  logic [mls_pkg::NUM_W-1:0] limit_r;
  logic [NW-1:0]             next_r, next_nxt;
  logic [NW-1:0]             clr_r, clr_nxt;
  logic [NW-1:0]             hwm_r, hwm_nxt;
  logic                      run_r, run_nxt;
  logic                      done_r, done_nxt;
  logic [PW-1:0]             pc_r, pc_nxt;
  logic [PW-1:0]             i_r, i_nxt;
  logic                      fin_r, fin_nxt;
  logic                      prime_r, prime_nxt;
  mls_pkg::mu_t              mu_n_r, mu_n_nxt;
  logic [NW-1:0]             spf_n_r, spf_n_nxt;
  logic [NW-1:0]             p_r, p_nxt;
  logic [MW-1:0]             m_r, m_nxt;

  logic                      out_valid_r;
  logic [mls_pkg::NUM_W-1:0] out_number_r;
  mls_pkg::mu_t              out_mobius_r;
  logic                      out_is_prime_r, out_last_r, out_finished_r;
  logic                      out_load;

  // memory ports
  logic           ent_we, ent_re;
  logic [NW-1:0]  ent_waddr, ent_raddr;
  logic [EDW-1:0] ent_wdata, ent_rdata;
  logic           pl_we, pl_re;
  logic [PIW-1:0] pl_waddr, pl_raddr;
  logic [NW-1:0]  pl_wdata, pl_rdata;

  // effective limit: min(limit, MAX_N)
  logic [LW-1:0] lim_ext;
  logic [NW-1:0] eff_lim;
  assign lim_ext = (LW'(limit_r) > LW'(MAX_N)) ? LW'(MAX_N) : LW'(limit_r);
  assign eff_lim = lim_ext[NW-1:0];

  // entry fields read for n
  logic [NW-1:0] rd_spf;
  mls_pkg::mu_t  rd_mu;
  assign rd_spf = ent_rdata[EDW-1:mls_pkg::MU_W];
  assign rd_mu  = mls_pkg::mu_t'(ent_rdata[mls_pkg::MU_W-1:0]);

  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    next_nxt  = next_r;
    clr_nxt   = clr_r;
    hwm_nxt   = hwm_r;
    run_nxt   = run_r;
    done_nxt  = done_r;
    pc_nxt    = pc_r;
    i_nxt     = i_r;
    fin_nxt   = fin_r;
    prime_nxt = prime_r;
    mu_n_nxt  = mu_n_r;
    spf_n_nxt = spf_n_r;
    p_nxt     = p_r;
    m_nxt     = m_r;
    ent_we    = 1'b0;
    ent_waddr = clr_r;
    ent_wdata = '0;
    ent_re    = 1'b0;
    ent_raddr = next_r;
    pl_we     = 1'b0;
    pl_waddr  = pc_r[PIW-1:0];
    pl_wdata  = next_r;
    pl_re     = 1'b0;
    pl_raddr  = i_r[PIW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_restart) begin
            pc_nxt    = '0;
            done_nxt  = 1'b0;
            next_nxt  = NW'(1);
            clr_nxt   = '0;
            run_nxt   = 1'b1;
            state_nxt = ST_CLR;
          end else begin
            state_nxt = ST_EVAL;
          end
        end
      end
      ST_CLR: begin
        // wipe one entry per cycle
        ent_we    = 1'b1;
        ent_waddr = clr_r;
        ent_wdata = '0;
        if (clr_r == hwm_r) begin
          hwm_nxt   = '0;
          run_nxt   = 1'b0;
          state_nxt = run_r ? ST_EVAL : ST_IDLE;
        end else begin
          clr_nxt = clr_r + NW'(1);
        end
      end
      ST_EVAL: begin
        prime_nxt = 1'b0;
        mu_n_nxt  = mls_pkg::MU_ZERO;
        if (done_r || (next_r > eff_lim) || (next_r == '0)) begin
          done_nxt  = 1'b1;
          fin_nxt   = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          fin_nxt   = 1'b0;
          ent_re    = 1'b1;
          ent_raddr = next_r;
          state_nxt = ST_NRD;
        end
      end
      ST_NRD: begin
        i_nxt     = '0;
        ent_waddr = next_r;
        if (next_r == NW'(1)) begin
          mu_n_nxt  = mls_pkg::MU_ONE;
          ent_we    = 1'b1;
          ent_wdata = {rd_spf, mls_pkg::MU_ONE};
          state_nxt = ST_OUT;
        end else if (rd_spf == '0) begin
          // unmarked: a new prime, its own smallest factor
          prime_nxt = 1'b1;
          mu_n_nxt  = mls_pkg::MU_NEG;
          spf_n_nxt = next_r;
          ent_we    = 1'b1;
          ent_wdata = {next_r, mls_pkg::MU_NEG};
          if (pc_r < PW'(PRIME_SLOTS)) begin
            pl_we  = 1'b1;
            pc_nxt = pc_r + PW'(1);
          end
          state_nxt = ST_WRD;
        end else begin
          mu_n_nxt  = rd_mu;
          spf_n_nxt = rd_spf;
          state_nxt = ST_WRD;
        end
        if (ent_we && (next_r > hwm_r)) begin
          hwm_nxt = next_r;
        end
      end
      ST_WRD: begin
        if (i_r < pc_r) begin
          pl_re     = 1'b1;
          state_nxt = ST_WMUL;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_WMUL: begin
        p_nxt     = pl_rdata;
        m_nxt     = MW'(next_r) * MW'(pl_rdata);
        state_nxt = ST_WCHK;
      end
      ST_WCHK: begin
        ent_waddr = m_r[NW-1:0];
        if (m_r > MW'(eff_lim)) begin
          state_nxt = ST_OUT;
        end else begin
          // mark n*p; p is its smallest factor
          ent_we = 1'b1;
          if (m_r[NW-1:0] > hwm_r) begin
            hwm_nxt = m_r[NW-1:0];
          end
          if (p_r == spf_n_r) begin
            ent_wdata = {p_r, mls_pkg::MU_ZERO};
            state_nxt = ST_OUT;
          end else begin
            ent_wdata = {p_r, mls_pkg::mu_t'(-mu_n_r)};
            i_nxt     = i_r + PW'(1);
            state_nxt = ST_WRD;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          if (!fin_r) begin
            next_nxt = next_r + NW'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      limit_r     <= mls_pkg::LIMIT_RESET;
      next_r      <= NW'(1);
      clr_r       <= '0;
      hwm_r       <= NW'(MAX_N);
      run_r       <= 1'b0;
      done_r      <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      next_r  <= next_nxt;
      clr_r   <= clr_nxt;
      hwm_r   <= hwm_nxt;
      run_r   <= run_nxt;
      done_r  <= done_nxt;
      pc_r    <= pc_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    fin_r   <= fin_nxt;
    prime_r <= prime_nxt;
    mu_n_r  <= mu_n_nxt;
    spf_n_r <= spf_n_nxt;
    p_r     <= p_nxt;
    m_r     <= m_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_number_r   <= fin_r ? '0 : mls_pkg::NUM_W'(next_r);
      out_mobius_r   <= fin_r ? mls_pkg::MU_ZERO : mu_n_r;
      out_is_prime_r <= fin_r ? 1'b0 : prime_r;
      out_last_r     <= fin_r ? 1'b0 : (next_r == eff_lim);
      out_finished_r <= fin_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_number   = out_number_r;
  assign out_mobius   = out_mobius_r;
  assign out_is_prime = out_is_prime_r;
  assign out_last     = out_last_r;
  assign out_finished = out_finished_r;

  // per-number store: {smallest prime factor, mu}; factor zero means unmarked
  mls_ram #(
    .DEPTH (MAX_N + 1),
    .AW    (NW),
    .DW    (EDW)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // prime list
  mls_ram #(
    .DEPTH (PRIME_SLOTS),
    .AW    (PIW),
    .DW    (NW)
  ) u_prime_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .re    (pl_re),
    .raddr (pl_raddr),
    .rdata (pl_rdata)
  );

  // checks
  `MLS_CHK(a_walk_idx, (state_r == ST_WRD), (i_r <= pc_r), "walk index past prime count")
  `MLS_CHK(a_pc_bound, 1'b1, (pc_r <= PW'(PRIME_SLOTS)), "prime count over slots")
  `MLS_CHK(a_mark_lim, (state_r == ST_WCHK) && ent_we, (m_r <= MW'(eff_lim)), "mark past limit")
  `MLS_CHK_NXT(a_clr_end, (state_r == ST_CLR) && (clr_r == hwm_r), (state_r != ST_CLR), "clear pass overran")

endmodule

/* rtl/mls_ram.sv */
// single-port-write, registered-read memory used for sieve state
`timescale 1ns / 1ps
module mls_ram #(
  parameter int DEPTH = 2,
  parameter int AW    = 1,
  parameter int DW    = 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
